// ===== rtl/sha1g_pkg.sv =====
package sha1g_pkg;

   localparam int unsigned WordWidth      = 32;
   localparam int unsigned NumRounds      = 80;
   localparam int unsigned RoundsPerPhase = 20;
   localparam int unsigned SchedDepth     = 16;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [SchedDepth-1:0] sched_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } work_type;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] mid;
      logic [31:0] low;
   } digest_type;

   typedef enum logic [1:0] {
      PH_CHOOSE   = 2'd0,
      PH_PARITY_A = 2'd1,
      PH_MAJORITY = 2'd2,
      PH_PARITY_B = 2'd3
   } phase_type;

   localparam word_type Iv0 = 32'h67452301;
   localparam word_type Iv1 = 32'hEFCDAB89;
   localparam word_type Iv2 = 32'h98BADCFE;
   localparam word_type Iv3 = 32'h10325476;
   localparam word_type Iv4 = 32'hC3D2E1F0;

   localparam word_type Rk0 = 32'h5A827999;
   localparam word_type Rk1 = 32'h6ED9EBA1;
   localparam word_type Rk2 = 32'h8F1BBCDC;
   localparam word_type Rk3 = 32'hCA62C1D6;

   localparam work_type WorkInit = '{a: Iv0, b: Iv1, c: Iv2, d: Iv3, e: Iv4};

   function automatic word_type round_k(input phase_type phase);
      word_type k;
      case (phase)
         PH_CHOOSE:   k = Rk0;
         PH_PARITY_A: k = Rk1;
         PH_MAJORITY: k = Rk2;
         PH_PARITY_B: k = Rk3;
         default:     k = Rk0;
      endcase
      return k;
   endfunction

   function automatic word_type round_f(input phase_type phase, input word_type b,
                                        input word_type c, input word_type d);
      word_type f;
      case (phase)
         PH_CHOOSE:   f = (b & c) | (~b & d);
         PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
         PH_PARITY_A,
         PH_PARITY_B: f = b ^ c ^ d;
         default:     f = b ^ c ^ d;
      endcase
      return f;
   endfunction

endpackage

// ===== rtl/sha1g_cell.sv =====
module sha1g_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  sha1g_pkg::phase_type phase,
   input  logic                valid_in,
   input  sha1g_pkg::work_type  work_in,
   input  sha1g_pkg::sched_type sched_in,
   output logic                valid_out,
   output sha1g_pkg::work_type  work_out,
   output sha1g_pkg::sched_type sched_out
);
   import sha1g_pkg::*;

   logic      valid_ff;
   work_type  work_ff, work_in_next;
   sched_type sched_ff, sched_in_next;
   word_type  temp, mix;

   // sched_in holds W[r..r+15]; slot 0 is this round's word
   always_comb begin
      temp = {work_in.a[26:0], work_in.a[31:27]}
           + round_f(phase, work_in.b, work_in.c, work_in.d)
           + work_in.e + round_k(phase) + sched_in[0];
      work_in_next.a = temp;
      work_in_next.b = work_in.a;
      work_in_next.c = {work_in.b[1:0], work_in.b[31:2]};
      work_in_next.d = work_in.c;
      work_in_next.e = work_in.d;

      mix = sched_in[13] ^ sched_in[8] ^ sched_in[2] ^ sched_in[0];
      for (int i = 0; i < SchedDepth - 1; i++) begin
         sched_in_next[i] = sched_in[i+1];
      end
      sched_in_next[SchedDepth-1] = {mix[30:0], mix[31]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         work_ff  <= work_in_next;
         sched_ff <= sched_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign work_out  = work_ff;
   assign sched_out = sched_ff;

endmodule

// ===== rtl/sha1g_out.sv =====
module sha1g_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sha1g_pkg::digest_type in_digest,
   output logic                  hold,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sha1g_pkg::digest_type rsp_digest
);
   import sha1g_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   digest_type out_ff, out_in;
   digest_type skid_ff;
   logic       out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      if (skid_valid_ff) begin
         // chain is frozen; drain the skid slot first
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = in_valid;
         out_in       = in_digest;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (!skid_valid_ff && !out_free && in_valid) begin
         skid_ff <= in_digest;
      end
   end

   assign hold       = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_digest = out_ff;

endmodule

// ===== rtl/sha1_g_function_160.sv =====
// SHA-1 based G function over a 160-bit value.
// Request channel: req_valid with req_value_high/mid/low (value bits 159..0,
// big-endian). A request is taken on a clock edge with req_valid high and
// req_stall low. The value is the first 20 bytes of an otherwise zero
// 64-byte block; no length padding is applied.
// Response channel: rsp_valid with rsp_digest_high/mid/low, taken on an edge
// with rsp_valid high and rsp_stall low. Exactly one response per request,
// in request order.
// The datapath is a chain of 80 round cells, one round and one register
// each, each carrying the working words and a 16-word schedule window.
// Each response passes the 80 cell registers and then the output register;
// throughput is one request per cycle, set by the one-round-per-cell chain,
// while req_stall is low. The output register plus a one-entry skid slot
// catch the digest that still leaves the chain as the receiver stalls;
// while the skid slot is occupied the whole chain holds and req_stall is high.
// Synchronous reset drops all in-flight requests and empties the output;
// the block keeps no state between requests.
module sha1_g_function_160 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value_high,
   input  logic [63:0] req_value_mid,
   input  logic [31:0] req_value_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_high,
   output logic [63:0] rsp_digest_mid,
   output logic [31:0] rsp_digest_low
);
   import sha1g_pkg::*;

   logic                  valid_chain [NumRounds+1];
   work_type              work_chain  [NumRounds+1];
   sched_type             sched_chain [NumRounds+1];
   logic                  hold;
   logic                  enable;
   digest_type            final_digest;
   digest_type            rsp_digest;

   assign enable    = !hold;
   assign req_stall = hold;

   assign valid_chain[0] = req_valid;
   assign work_chain[0]  = WorkInit;
   // slot 0 (lowest word) is message word 0; words 5..15 are zero
   assign sched_chain[0] = {352'd0, req_value_low,
                            req_value_mid[31:0], req_value_mid[63:32],
                            req_value_high[31:0], req_value_high[63:32]};

   for (genvar r = 0; r < NumRounds; r++) begin : g_round
      localparam phase_type Phase = phase_type'(r / RoundsPerPhase);
      sha1g_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .phase     (Phase),
         .valid_in  (valid_chain[r]),
         .work_in   (work_chain[r]),
         .sched_in  (sched_chain[r]),
         .valid_out (valid_chain[r+1]),
         .work_out  (work_chain[r+1]),
         .sched_out (sched_chain[r+1])
      );
   end

   always_comb begin
      final_digest.high = {work_chain[NumRounds].a + Iv0, work_chain[NumRounds].b + Iv1};
      final_digest.mid  = {work_chain[NumRounds].c + Iv2, work_chain[NumRounds].d + Iv3};
      final_digest.low  = work_chain[NumRounds].e + Iv4;
   end

   sha1g_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_chain[NumRounds]),
      .in_digest  (final_digest),
      .hold       (hold),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_digest (rsp_digest)
   );

   assign rsp_digest_high = rsp_digest.high;
   assign rsp_digest_mid  = rsp_digest.mid;
   assign rsp_digest_low  = rsp_digest.low;

endmodule
